// ===== rtl/core/half_single_float_converter_unit_macros.svh =====
// Assertion macros for the converter unit
`ifndef HALF_SINGLE_FLOAT_CONVERTER_UNIT_MACROS_SVH
`define HALF_SINGLE_FLOAT_CONVERTER_UNIT_MACROS_SVH
`ifndef SYNTH
`define HSFC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define HSFC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define HSFC_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define HSFC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/core/hsfc_pkg.sv =====
package hsfc_pkg;

  typedef struct packed {
    logic        func;
    logic [31:0] single_bits;
    logic [15:0] half_bits;
  } hsfc_in_t;

  typedef struct packed {
    logic [15:0] half_result;
    logic [31:0] single_result;
  } hsfc_out_t;

  localparam logic FUNC_S2H = 1'b0;
  localparam logic FUNC_H2S = 1'b1;

  // number of pipeline stages
  localparam int unsigned STAGES = 3;

  // Decoded class of an item after stage one
  typedef enum logic [2:0] {
    CLS_S2H_NORM,
    CLS_S2H_SUB,
    CLS_S2H_ZERO,
    CLS_S2H_INF,
    CLS_S2H_NAN,
    CLS_H2S_NORM,
    CLS_H2S_SUB,
    CLS_H2S_ZERO
  } hsfc_cls_t;

  typedef struct packed {
    hsfc_cls_t   cls;
    logic        sign;
    logic [7:0]  expo;    // single exponent or half exponent zero-extended
    logic [22:0] frac;
  } hsfc_dec_t;

  typedef struct packed {
    hsfc_cls_t   cls;
    logic        sign;
    logic [7:0]  expo;
    logic [24:0] sum;     // rounded significand
    logic [3:0]  lead;    // normalizing shift of half subnormal (leading zeros plus one)
    logic [9:0]  hfrac;
  } hsfc_rnd_t;

endpackage

// ===== rtl/core/hsfc_stage.sv =====
// One pipeline register stage with valid/ready flow control
module hsfc_stage import hsfc_pkg::*; #(
  parameter int unsigned Width = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             up_valid,
  output logic             up_ready,
  input  logic [Width-1:0] up_data,
  output logic             dn_valid,
  input  logic             dn_ready,
  output logic [Width-1:0] dn_data
);

  logic             valid_r;
  logic             valid_nxt;
  logic [Width-1:0] data_r;

  // advance when downstream takes or stage is empty
  assign up_ready  = dn_ready || !valid_r;
  assign valid_nxt = up_ready ? up_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= up_data;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

// ===== rtl/core/hsfc_decode.sv =====
// Stage one logic: classify the operand
module hsfc_decode import hsfc_pkg::*; (
  input  hsfc_in_t  item,
  output hsfc_dec_t dec
);

  logic [7:0] se;
  logic [4:0] he;

  always_comb begin
    se = item.single_bits[30:23];
    he = item.half_bits[14:10];
    if (item.func == FUNC_S2H) begin
      dec.sign = item.single_bits[31];
      dec.expo = se;
      dec.frac = item.single_bits[22:0];
      if (se == 8'hff) begin
        dec.cls = (item.single_bits[22:0] == '0) ? CLS_S2H_INF : CLS_S2H_NAN;
      end else if (se >= 8'd143) begin
        dec.cls = CLS_S2H_INF;
      end else if (se < 8'd102) begin
        dec.cls = CLS_S2H_ZERO;
      end else if (se <= 8'd112) begin
        dec.cls = CLS_S2H_SUB;
      end else begin
        dec.cls = CLS_S2H_NORM;
      end
    end else begin
      dec.sign = item.half_bits[15];
      dec.expo = {3'b000, he};
      dec.frac = {item.half_bits[9:0], 13'b0};
      if (he != 5'd0) begin
        dec.cls = CLS_H2S_NORM;
      end else if (item.half_bits[9:0] == '0) begin
        dec.cls = CLS_H2S_ZERO;
      end else begin
        dec.cls = CLS_H2S_SUB;
      end
    end
  end

endmodule

// ===== rtl/core/hsfc_round.sv =====
// Stage two logic: round the significand, count leading zeros
module hsfc_round import hsfc_pkg::*; (
  input  hsfc_dec_t dec,
  output hsfc_rnd_t rnd
);

  logic [23:0] sig;
  logic [4:0]  sh;
  logic [9:0]  hf;
  logic [3:0]  lz;

  always_comb begin
    sig = {1'b1, dec.frac};
    // shift 14..24 for subnormal half results
    sh  = 5'(8'd126 - dec.expo);
    hf  = dec.frac[22:13];
    lz  = 4'd0;
    for (int i = 9; i >= 0; i--) begin
      if (hf[i] && lz == 4'd0) begin
        lz = 4'(10 - i);
      end
    end
    rnd.cls  = dec.cls;
    rnd.sign = dec.sign;
    rnd.expo = dec.expo;
    rnd.lead = lz;
    // normalize the mantissa only for half subnormals
    rnd.hfrac = (dec.cls == CLS_H2S_SUB) ? 10'(hf << lz) : hf;
    case (dec.cls)
      CLS_S2H_SUB:  rnd.sum = 25'(({1'b0, sig} + (25'd1 << (sh - 5'd1))) >> sh);
      CLS_S2H_NORM: rnd.sum = {2'b0, dec.frac} + 25'h1000;
      default:      rnd.sum = '0;
    endcase
  end

endmodule

// ===== rtl/core/hsfc_pack.sv =====
// Stage three logic: assemble the result item
module hsfc_pack import hsfc_pkg::*; (
  input  hsfc_rnd_t rnd,
  output hsfc_out_t res
);

  logic [5:0] hexp;
  logic [9:0] top;

  always_comb begin
    res  = '0;
    hexp = 6'(rnd.expo - 8'd112);
    top  = rnd.sum[22:13];
    case (rnd.cls)
      CLS_S2H_NAN: begin
        res.half_result = {rnd.sign, 5'h1f, rnd.sum[9:0]};
      end
      CLS_S2H_INF:  res.half_result = {rnd.sign, 15'h7c00};
      CLS_S2H_ZERO: res.half_result = {rnd.sign, 15'h0};
      CLS_S2H_SUB:  res.half_result = {rnd.sign, rnd.sum[14:0]};
      CLS_S2H_NORM: begin
        // carry out of the mantissa bumps the exponent
        if (rnd.sum[23]) begin
          hexp = hexp + 6'd1;
          top  = '0;
        end
        if (hexp >= 6'd31) begin
          res.half_result = {rnd.sign, 15'h7c00};
        end else begin
          res.half_result = {rnd.sign, hexp[4:0], top};
        end
      end
      CLS_H2S_ZERO: res.single_result = {rnd.sign, 31'h0};
      CLS_H2S_SUB: begin
        res.single_result = {rnd.sign, 8'(8'd113 - {4'b0, rnd.lead}), rnd.hfrac, 13'b0};
      end
      CLS_H2S_NORM: begin
        if (rnd.expo[4:0] == 5'h1f) begin
          res.single_result = {rnd.sign, 8'hff, rnd.hfrac, 13'b0};
        end else begin
          res.single_result = {rnd.sign, 8'(rnd.expo + 8'd112), rnd.hfrac, 13'b0};
        end
      end
      default: res = '0;
    endcase
  end

endmodule

// ===== rtl/core/half_single_float_converter_unit.sv =====
// Half/single float converter unit.
// Input channel in_valid/in_ready/in_data (hsfc_in_t): func 0 converts
// single_bits to half, func 1 converts half_bits to single.
// Result channel out_valid/out_ready/out_data (hsfc_out_t): the unused
// result field reads zero. Single to half rounds half away from zero,
// overflows to infinity, flushes tiny values to zero.
// Three register stages (decode, round, pack) lie between acceptance and
// out_valid. One item per cycle while the receiver keeps out_ready high.
// Each stage is one register slot with its own valid bit; a stage moves
// when the next one is empty or being emptied, so a stalled receiver
// backs the pipeline up without loss and in_ready drops once all three
// stages hold items.
// Reset (rst_n low, synchronous) empties every stage by clearing its valid bit; data registers are not reset.
`include "half_single_float_converter_unit_macros.svh"
module half_single_float_converter_unit import hsfc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  hsfc_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output hsfc_out_t out_data
);

  hsfc_dec_t dec_c, dec_q;
  hsfc_rnd_t rnd_c, rnd_q;
  hsfc_out_t res_c;
  logic v1, r1, v2, r2;

  hsfc_decode u_dec (.item(in_data), .dec(dec_c));

  // pass the decoded item to stage one
  hsfc_dec_t dec_f;
  always_comb begin
    dec_f = dec_c;
  end

  hsfc_stage #(.Width($bits(hsfc_dec_t))) u_s1 (
    .clk, .rst_n, .up_valid(in_valid), .up_ready(in_ready), .up_data(dec_f),
    .dn_valid(v1), .dn_ready(r1), .dn_data(dec_q));

  hsfc_round u_rnd (.dec(dec_q), .rnd(rnd_c));

  // keep NaN payload nonzero
  hsfc_rnd_t rnd_f;
  always_comb begin
    rnd_f = rnd_c;
    if (dec_q.cls == CLS_S2H_NAN) begin
      rnd_f.sum = {15'b0, dec_q.frac[22:13]};
      if (dec_q.frac[22:13] == '0) begin
        rnd_f.sum = 25'd1;
      end
    end
  end

  hsfc_stage #(.Width($bits(hsfc_rnd_t))) u_s2 (
    .clk, .rst_n, .up_valid(v1), .up_ready(r1), .up_data(rnd_f),
    .dn_valid(v2), .dn_ready(r2), .dn_data(rnd_q));

  hsfc_pack u_pack (.rnd(rnd_q), .res(res_c));

  hsfc_stage #(.Width($bits(hsfc_out_t))) u_s3 (
    .clk, .rst_n, .up_valid(v2), .up_ready(r2), .up_data(res_c),
    .dn_valid(out_valid), .dn_ready(out_ready), .dn_data(out_data));

  // checks
  `HSFC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `HSFC_ASSERT_IMPL(a_full_stall, clk, rst_n, v1 && v2 && out_valid && !out_ready, !in_ready)
  `HSFC_ASSERT_IMPL(a_one_side, clk, rst_n, out_valid,
    out_data.half_result == '0 || out_data.single_result == '0)

endmodule
